/* hw/rtl/ngrp_pkg.sv */
// Package: shared constants and types for the NMEA GGA/RMC stream parser.
package ngrp_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [3:0] FIELD_MAX  = 4'd15;
	localparam logic [3:0] FIELD_TIME = 4'd1;
	localparam logic [3:0] FIELD_FIX  = 4'd6;
	localparam logic [3:0] FIELD_SATS = 4'd7;
	localparam logic [3:0] FIELD_DATE = 4'd9;
	localparam logic [3:0] GGA_MIN_FIELDS = 4'd8;
	localparam logic [3:0] RMC_MIN_FIELDS = 4'd10;
	localparam logic [16:0] MAG_MAX = 17'd65535;
	localparam logic [7:0] MAX_SATS_RESET = 8'd50;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_GGA   = 2'd1,
		KIND_RMC   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} num_phase_t;

	typedef struct packed {
		logic [15:0] mag;
		num_phase_t  phase;
		logic        neg;
		logic        nonempty;
	} num_t;

	// sentence summary handed from the scanner to the commit stage
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  count;
		logic [47:0] ptime;
		logic [47:0] pfrac;
		logic [4:0]  ptime_len;
		logic [47:0] pdate;
		logic [4:0]  pdate_len;
		num_t        fix;
		num_t        sats;
	} sentence_t;

	function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] p);
		logic [39:0] s;
		begin
			case (k)
				2'd0: s = "GPGGA";
				2'd1: s = "GNGGA";
				2'd2: s = "GPRMC";
				default: s = "GNRMC";
			endcase
			cand_char = s[8*(4-p) +: 8];
		end
	endfunction

	function automatic num_t num_feed(input num_t n, input logic [7:0] c);
		logic digit;
		logic [19:0] acc;
		num_t r;
		begin
			r = n;
			digit = (c >= CH_ZERO) && (c <= CH_NINE);
			r.nonempty = 1'b1;
			acc = {4'd0, n.mag} * 20'd10 + {12'd0, c - CH_ZERO};
			case (n.phase)
				PH_SKIP: begin
					if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
						r.phase = PH_SKIP;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						r.neg = (c == CH_MINUS);
						r.phase = PH_DIGITS;
					end else if (digit) begin
						r.phase = PH_DIGITS;
						r.mag = {8'd0, c - CH_ZERO};
					end else begin
						r.phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (digit) begin
						r.mag = (acc > {3'd0, MAG_MAX}) ? MAG_MAX[15:0] : acc[15:0];
					end else begin
						r.phase = PH_DONE;
					end
				end
				default: r = r;
			endcase
			num_feed = r;
		end
	endfunction

endpackage

/* hw/rtl/nmea_gga_rmc_stream_parser.sv */
// Top level: NMEA GGA/RMC stream parser with max-satellites register.
// Takes one received byte per cycle while in_stall is low. Each LF that ends a
// sentence produces one result in the next cycle, carrying the sentence kind
// and the committed fix, satellites, time and date. The result sits in an
// output register; a new byte is accepted whenever that register is empty,
// being taken, or when the byte produces no result.
module nmea_gga_rmc_stream_parser #(
	parameter int SENTENCE_BYTES = 128,
	parameter int FIELD_CHARS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  sentence_kind,
	output logic        has_fix,
	output logic [7:0]  satellites,
	output logic        time_ok,
	output logic [47:0] time_hhmmss,
	output logic [47:0] time_fraction,
	output logic [2:0]  time_fraction_len,
	output logic        date_ok,
	output logic [47:0] date_ddmmyy
);

	logic [7:0] max_sats_q;
	logic       done;
	logic       lf_end;
	logic       take;
	ngrp_pkg::sentence_t sent;

	assign in_stall = out_valid && out_stall && lf_end;
	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_sats_q <= ngrp_pkg::MAX_SATS_RESET;
		else if (cfg_valid)
			max_sats_q <= cfg_data;
	end

	ngrp_scan #(
		.SENTENCE_BYTES(SENTENCE_BYTES),
		.FIELD_CHARS(FIELD_CHARS)
	) u_scan (
		.clk(clk), .arst_n(arst_n), .in_valid(take), .in_byte(rx_byte),
		.lf_end(lf_end), .done(done), .sent(sent)
	);

	ngrp_commit u_commit (
		.clk(clk), .arst_n(arst_n), .done(done), .sent(sent), .max_sats(max_sats_q),
		.out_stall(out_stall), .out_valid(out_valid),
		.sentence_kind(sentence_kind), .has_fix(has_fix), .satellites(satellites),
		.time_ok(time_ok), .time_hhmmss(time_hhmmss),
		.time_fraction(time_fraction), .time_fraction_len(time_fraction_len),
		.date_ok(date_ok), .date_ddmmyy(date_ddmmyy)
	);

endmodule

/* hw/rtl/ngrp_scan.sv */
// Scanner: per-byte sentence framing, field splitting, prefix match and field capture.
module ngrp_scan #(
	parameter int SENTENCE_BYTES = 128,
	parameter int FIELD_CHARS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	output logic                 lf_end,
	output logic                 done,
	output ngrp_pkg::sentence_t  sent
);

	localparam int BW = $clog2(SENTENCE_BYTES);
	localparam int FW = $clog2(FIELD_CHARS);
	localparam logic [BW-1:0] BYTE_LIM = BW'(SENTENCE_BYTES - 1);
	localparam logic [FW-1:0] FLD_LIM = FW'(FIELD_CHARS - 1);

	logic [BW-1:0] byte_count_q;
	logic [3:0]    field_number_q;
	logic [FW-1:0] field_length_q;
	logic [3:0]    prefix_q;
	logic          zero_seen_q;
	logic [47:0]   ptime_q, pfrac_q, pdate_q;
	logic [4:0]    ptime_len_q, pdate_len_q;
	ngrp_pkg::num_t fix_q, sats_q;

	logic [3:0]    prefix_d;
	logic [3:0]    field_d;
	logic [FW-1:0] p;
	logic [5:0]    pw;
	logic [4:0]    plen;
	logic          active, sep, keep;
	logic [3:0]    cnt;

	assign active = in_valid && in_byte != ngrp_pkg::CH_DOLLAR &&
		byte_count_q != '0 && byte_count_q < BYTE_LIM;
	assign sep = in_byte == ngrp_pkg::CH_COMMA || in_byte == ngrp_pkg::CH_STAR ||
		in_byte == ngrp_pkg::CH_CR || in_byte == ngrp_pkg::CH_LF;
	assign keep = active && !zero_seen_q && in_byte != 8'd0 && !sep &&
		field_length_q < FLD_LIM;
	assign p = field_length_q;
	assign pw = 6'(p);
	assign plen = (pw + 6'd1 > 6'd31) ? 5'd31 : 5'(pw + 6'd1);

	always_comb begin
		prefix_d = prefix_q;
		if (byte_count_q >= BW'(1) && byte_count_q <= BW'(5)) begin
			for (int k = 0; k < 4; k++) begin
				if (ngrp_pkg::cand_char(2'(k), 3'(byte_count_q - BW'(1))) != in_byte)
					prefix_d[k] = 1'b0;
			end
		end
		field_d = field_number_q;
		if (!zero_seen_q && in_byte != 8'd0 && sep && field_number_q < ngrp_pkg::FIELD_MAX)
			field_d = field_number_q + 4'd1;
		cnt = field_d;
		if (zero_seen_q && field_length_q != '0 && cnt < ngrp_pkg::FIELD_MAX)
			cnt = cnt + 4'd1;
	end

	always_comb begin
		sent.kind = prefix_d[1:0] != 2'b00 ? ngrp_pkg::KIND_GGA :
			prefix_d[3:2] != 2'b00 ? ngrp_pkg::KIND_RMC : ngrp_pkg::KIND_OTHER;
		sent.count = cnt;
		sent.ptime = ptime_q;
		sent.pfrac = pfrac_q;
		sent.ptime_len = ptime_len_q;
		sent.pdate = pdate_q;
		sent.pdate_len = pdate_len_q;
		sent.fix = fix_q;
		sent.sats = sats_q;
	end

	// byte on the input would close an open sentence
	assign lf_end = in_byte == ngrp_pkg::CH_LF && byte_count_q != '0 &&
		byte_count_q < BYTE_LIM;
	assign done = active && in_byte == ngrp_pkg::CH_LF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			field_number_q <= '0;
			field_length_q <= '0;
			prefix_q <= 4'hF;
			zero_seen_q <= 1'b0;
			ptime_q <= '0;
			pfrac_q <= '0;
			pdate_q <= '0;
			ptime_len_q <= '0;
			pdate_len_q <= '0;
			fix_q <= '0;
			sats_q <= '0;
		end else if (in_valid && in_byte == ngrp_pkg::CH_DOLLAR) begin
			byte_count_q <= BW'(1);
			field_number_q <= '0;
			field_length_q <= '0;
			prefix_q <= 4'hF;
			zero_seen_q <= 1'b0;
			ptime_q <= '0;
			pfrac_q <= '0;
			pdate_q <= '0;
			ptime_len_q <= '0;
			pdate_len_q <= '0;
			fix_q <= '0;
			sats_q <= '0;
		end else if (active) begin
			byte_count_q <= (in_byte == ngrp_pkg::CH_LF) ? '0 : byte_count_q + BW'(1);
			prefix_q <= prefix_d;
			if (!zero_seen_q) begin
				if (in_byte == 8'd0) begin
					zero_seen_q <= 1'b1;
				end else if (sep) begin
					field_number_q <= field_d;
					field_length_q <= '0;
				end
			end
			if (keep) begin
				field_length_q <= p + FW'(1);
				case (field_number_q)
					ngrp_pkg::FIELD_TIME: begin
						if (pw < 6'd6)
							ptime_q[8*(5-pw) +: 8] <= in_byte;
						else if (pw < 6'd12)
							pfrac_q[8*(11-pw) +: 8] <= in_byte;
						ptime_len_q <= plen;
					end
					ngrp_pkg::FIELD_FIX: fix_q <= ngrp_pkg::num_feed(fix_q, in_byte);
					ngrp_pkg::FIELD_SATS: sats_q <= ngrp_pkg::num_feed(sats_q, in_byte);
					ngrp_pkg::FIELD_DATE: begin
						if (pw < 6'd6)
							pdate_q[8*(5-pw) +: 8] <= in_byte;
						pdate_len_q <= plen;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* hw/rtl/ngrp_commit.sv */
// Commit stage: stored fix, satellites, time and date; registered result.
module ngrp_commit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                done,
	input  ngrp_pkg::sentence_t sent,
	input  logic [7:0]          max_sats,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          sentence_kind,
	output logic                has_fix,
	output logic [7:0]          satellites,
	output logic                time_ok,
	output logic [47:0]         time_hhmmss,
	output logic [47:0]         time_fraction,
	output logic [2:0]          time_fraction_len,
	output logic                date_ok,
	output logic [47:0]         date_ddmmyy
);

	logic        fix_q, tv_q, dv_q;
	logic [7:0]  sats_q;
	logic [47:0] time_q, frac_q, date_q;
	logic [2:0]  flen_q;

	logic        fix_d, tv_d, dv_d;
	logic [7:0]  sats_d;
	logic [47:0] time_d, frac_d, date_d;
	logic [2:0]  flen_d;
	logic [4:0]  fl;
	logic        gga_ok;

	always_comb begin
		fix_d = fix_q; tv_d = tv_q; dv_d = dv_q; sats_d = sats_q;
		time_d = time_q; frac_d = frac_q; date_d = date_q; flen_d = flen_q;
		fl = sent.ptime_len - 5'd6;
		gga_ok = sent.kind == ngrp_pkg::KIND_GGA && sent.count >= ngrp_pkg::GGA_MIN_FIELDS;
		if (gga_ok) begin
			if (sent.ptime_len >= 5'd6) begin
				time_d = sent.ptime;
				frac_d = sent.pfrac;
				flen_d = fl > 5'd6 ? 3'd6 : fl[2:0];
				tv_d = 1'b1;
			end
			if (sent.fix.nonempty)
				fix_d = !sent.fix.neg && sent.fix.mag != 16'd0;
			if (sent.sats.nonempty && (sent.sats.mag == 16'd0 ||
				(!sent.sats.neg && sent.sats.mag <= {8'd0, max_sats})))
				sats_d = sent.sats.mag[7:0];
		end
		if (sent.kind == ngrp_pkg::KIND_RMC && sent.count >= ngrp_pkg::RMC_MIN_FIELDS &&
			sent.pdate_len == 5'd6) begin
			date_d = sent.pdate;
			dv_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_q <= 1'b0; tv_q <= 1'b0; dv_q <= 1'b0; sats_q <= '0;
			time_q <= '0; frac_q <= '0; date_q <= '0; flen_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (done) begin
				fix_q <= fix_d; tv_q <= tv_d; dv_q <= dv_d; sats_q <= sats_d;
				time_q <= time_d; frac_q <= frac_d; date_q <= date_d; flen_q <= flen_d;
			end
			if (done)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			sentence_kind <= sent.kind;
			has_fix <= fix_d;
			satellites <= sats_d;
			time_ok <= tv_d;
			time_hhmmss <= time_d;
			time_fraction <= frac_d;
			time_fraction_len <= flen_d;
			date_ok <= dv_d;
			date_ddmmyy <= date_d;
		end
	end

endmodule
